>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define WBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds.
`define WBS_ASSERT_NEVER(lbl, cond, msg) \
  `WBS_ASSERT(lbl, !(cond), msg)
`else
`define WBS_ASSERT(lbl, prop, msg)
`define WBS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/wbs_pkg.sv
// Package for the weighted best-of-two selector: constants and codes.
`timescale 1ns / 1ps
`default_nettype none
package wbs_pkg;
  localparam int DefMaxTargets = 16;

  localparam int CountW  = 32;
  localparam int WeightW = 8;
  localparam int RandW   = 31;
  localparam int IdxW    = 4;

  // command codes
  localparam logic [1:0] CMD_SELECT    = 2'd0;
  localparam logic [1:0] CMD_WR_COUNT  = 2'd1;
  localparam logic [1:0] CMD_WR_WEIGHT = 2'd2;

  // register word indexes
  localparam logic REG_ACTIVE_TARGETS = 1'b0;

  localparam logic [4:0] ActiveReset = 5'd16;
endpackage
`default_nettype wire

>>> rtl/core/wbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/weighted_best_of_two_selector_top.sv
// Top level of the weighted best-of-two selector.
//
//  channel  | direction | tdata                                | tuser
//  s_axis   | in        | index, value, mask, rand1, rand2     | command
//  m_axis   | out       | chosen_target                        | no_target
//  apb      | in/out    | active_targets at address 0          | -
//
// Writes can follow each other in consecutive cycles.
// A select passes through 31 bit-serial remainder steps for both candidate
// positions, a scan of the untried mask, the table reads on the single read
// port (RD1, RD2, RD3) and 32 restoring division steps for both lease counts,
// then the output state. With no untried target it goes from the remainder
// steps straight to the output state.
// Reset clears the table valid bits, so all entries read as zero.
// Input is taken only while idle; a result waits in the output register
// and does not block the next item, but a finished select holds while it is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module weighted_best_of_two_selector_top
  import wbs_pkg::*;
#(
  parameter int MAX_TARGETS = DefMaxTargets
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] target_index, [35:4] write_value, [51:36] tried_mask,
  // [82:52] rand_first, [113:83] rand_second, [119:114] zero
  input  wire logic [119:0] s_axis_tdata,
  // [1:0] command
  input  wire logic [1:0]   s_axis_tuser,
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [3:0] chosen_target, [7:4] zero
  output logic      [7:0]   m_axis_tdata,
  // [0] no_target
  output logic      [0:0]   m_axis_tuser,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  localparam int IW = $clog2(MAX_TARGETS);
  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam int XW = (IW > IdxW) ? IW : IdxW;
  localparam int MW = (MAX_TARGETS < 16) ? MAX_TARGETS : 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_RD2  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_RD3  = 3'd7;

  // input unpacking
  logic [IdxW-1:0]    in_index;
  logic [CountW-1:0]  in_value;
  logic [15:0]        in_mask;
  logic [RandW-1:0]   in_rand1, in_rand2;
  logic [1:0]         in_cmd;
  logic               in_acc;
  assign in_index = s_axis_tdata[3:0];
  assign in_value = s_axis_tdata[35:4];
  assign in_mask  = s_axis_tdata[51:36];
  assign in_rand1 = s_axis_tdata[82:52];
  assign in_rand2 = s_axis_tdata[113:83];
  assign in_cmd   = s_axis_tuser;

  logic [2:0] state_q, state_d;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // configuration register
  logic [4:0] active_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACTIVE_TARGETS) ? {27'd0, active_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_TARGETS) begin
      active_q <= pwdata[4:0];
    end
  end

  // table write decode
  logic [XW-1:0] widx_ext;
  logic          widx_ok, we_cnt, we_wgt;
  logic [IW-1:0] waddr;
  assign widx_ext = XW'(in_index);
  assign widx_ok  = (int'(widx_ext) < MAX_TARGETS);
  assign waddr    = widx_ext[IW-1:0];
  assign we_cnt   = in_acc && in_cmd == CMD_WR_COUNT && widx_ok;
  assign we_wgt   = in_acc && in_cmd == CMD_WR_WEIGHT && widx_ok;

  // valid bits: unwritten entries read as zero
  logic [MAX_TARGETS-1:0] cnt_vld_q, wgt_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      wgt_vld_q <= '0;
    end else begin
      if (we_cnt) cnt_vld_q[waddr] <= 1'b1;
      if (we_wgt) wgt_vld_q[waddr] <= 1'b1;
    end
  end

  logic [IW-1:0]      raddr;
  logic               re;
  logic [CountW-1:0]  cnt_rdata;
  logic [WeightW-1:0] wgt_rdata;

  wbs_ram #(.Width(CountW), .Depth(MAX_TARGETS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (we_cnt),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (cnt_rdata)
  );

  wbs_ram #(.Width(WeightW), .Depth(MAX_TARGETS)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (we_wgt),
    .waddr_i (waddr),
    .wdata_i (in_value[WeightW-1:0]),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (wgt_rdata)
  );

  // untried mask of a select, limited to the active targets
  logic [MAX_TARGETS-1:0] umask_d;
  always_comb begin
    for (int i = 0; i < MAX_TARGETS; i++) begin
      umask_d[i] = (i < int'(active_q)) && !((i < MW) && in_mask[i]);
    end
  end

  // working registers
  logic [MAX_TARGETS-1:0] umask_q;
  logic [RandW-1:0]       r1_q, r2_q;
  logic [CW-1:0]          j_q, rem1_q, rem2_q, pos1_q, pos2_q, rank_q;
  logic [4:0]             step_q;
  logic [IW-1:0]          scan_q, first_q, second_q;
  logic [CountW-1:0]      dq1_q, dq2_q;
  logic [WeightW:0]       dv1_q, dv2_q, dr1_q, dr2_q;
  logic [IW-1:0]          res_idx_q;
  logic                   res_none_q;

  // one remainder step for each candidate position
  logic [CW:0]   t1, t2;
  logic [CW-1:0] jm1, nrem1, nrem2, p2_raw;
  assign jm1 = j_q - CW'(1);
  assign t1  = {rem1_q, r1_q[RandW-1]};
  assign t2  = {rem2_q, r2_q[RandW-1]};
  assign nrem1 = (t1 >= {1'b0, j_q}) ? CW'(t1 - {1'b0, j_q}) : CW'(t1);
  assign nrem2 = (t2 >= {1'b0, jm1}) ? CW'(t2 - {1'b0, jm1}) : CW'(t2);
  assign p2_raw = (nrem2 >= nrem1) ? nrem2 + CW'(1) : nrem2;

  // one restoring division step for each candidate load
  logic [WeightW+1:0] u1, u2;
  logic               qb1, qb2;
  assign u1  = {dr1_q, dq1_q[CountW-1]};
  assign u2  = {dr2_q, dq2_q[CountW-1]};
  assign qb1 = (u1 >= {1'b0, dv1_q});
  assign qb2 = (u2 >= {1'b0, dv2_q});

  logic [CountW-1:0] q1_fin, q2_fin;
  assign q1_fin = {dq1_q[CountW-2:0], qb1};
  assign q2_fin = {dq2_q[CountW-2:0], qb2};

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // read port address
  always_comb begin
    re    = (state_q == S_RD1) || (state_q == S_RD2);
    raddr = (state_q == S_RD1) ? first_q : second_q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_cmd == CMD_SELECT) state_d = S_MOD;
      S_MOD:  if (step_q == 5'd0) state_d = (j_q == '0) ? S_OUT : S_SCAN;
      S_SCAN: if (int'(scan_q) == MAX_TARGETS - 1) state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_RD3;
      S_RD3:  state_d = S_DIV;
      S_DIV:  if (step_q == 5'd0) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        umask_q <= umask_d;
        r1_q    <= in_rand1;
        r2_q    <= in_rand2;
        rem1_q  <= '0;
        rem2_q  <= '0;
        step_q  <= 5'(RandW - 1);
        j_q     <= CW'($countones(umask_d));
      end
      S_MOD: begin
        rem1_q <= nrem1;
        rem2_q <= nrem2;
        r1_q   <= r1_q << 1;
        r2_q   <= r2_q << 1;
        step_q <= step_q - 5'd1;
        pos1_q <= nrem1;
        pos2_q <= p2_raw;
        scan_q <= '0;
        rank_q <= '0;
        first_q  <= '0;
        second_q <= '0;
        res_idx_q  <= '0;
        res_none_q <= 1'b1;
      end
      S_SCAN: begin
        if (umask_q[scan_q]) begin
          if (rank_q == pos1_q) first_q <= scan_q;
          if (rank_q == pos2_q) second_q <= scan_q;
          rank_q <= rank_q + CW'(1);
        end
        scan_q <= scan_q + IW'(1);
      end
      S_RD1: ;
      // first candidate data arrives
      S_RD2: begin
        dq1_q <= cnt_vld_q[first_q] ? cnt_rdata : '0;
        dv1_q <= (wgt_vld_q[first_q] ? {1'b0, wgt_rdata} : '0) + (WeightW+1)'(1);
        dr1_q <= '0;
      end
      // second candidate data arrives in the following cycle
      S_RD3: begin
        dq2_q  <= cnt_vld_q[second_q] ? cnt_rdata : '0;
        dv2_q  <= (wgt_vld_q[second_q] ? {1'b0, wgt_rdata} : '0) + (WeightW+1)'(1);
        dr2_q  <= '0;
        step_q <= 5'(CountW - 1);
      end
      S_DIV: begin
        dr1_q  <= qb1 ? (WeightW+1)'(u1 - {1'b0, dv1_q}) : (WeightW+1)'(u1);
        dq1_q  <= q1_fin;
        dr2_q  <= qb2 ? (WeightW+1)'(u2 - {1'b0, dv2_q}) : (WeightW+1)'(u2);
        dq2_q  <= q2_fin;
        step_q <= step_q - 5'd1;
        res_none_q <= 1'b0;
        if (j_q == CW'(1) || q1_fin < q2_fin) begin
          res_idx_q <= first_q;
        end else begin
          res_idx_q <= second_q;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // output register
  logic          m_valid_q;
  logic [IW-1:0] m_idx_q;
  logic          m_none_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      m_idx_q  <= res_idx_q;
      m_none_q <= res_none_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, 4'(m_idx_q)};
  assign m_axis_tuser  = m_none_q;

  `WBS_ASSERT(a_none_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0,
              "no_target result carries a nonzero index")
  `WBS_ASSERT(a_sel_busy, in_acc && in_cmd == CMD_SELECT |=> !s_axis_tready,
              "select accepted but input still ready")
  `WBS_ASSERT(a_out_src, $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT,
              "result appeared without a finished select")
endmodule
`default_nettype wire

>>> bench/weighted_best_of_two_selector_top_test.sv
// Self-checking bench for the weighted best-of-two selector: table, random and stall stimulus.
`timescale 1ns / 1ps
`default_nettype none
module weighted_best_of_two_selector_top_test
  import wbs_pkg::*;
();

  localparam int NumTargets = 16;
  localparam int LongHoldCycles = 400;

  // one command item as it travels on the slave side
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  target_index;
    logic [31:0] write_value;
    logic [15:0] tried_mask;
    logic [30:0] rand_first;
    logic [30:0] rand_second;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] chosen_target;
    logic       no_target;
  } pick_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  weighted_best_of_two_selector_top DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow copy of the block state
  logic [31:0] lease_shadow [NumTargets];
  logic [7:0]  weight_shadow [NumTargets];
  logic [4:0]  active_shadow;

  pick_t pending_picks[$];
  int    mismatches;
  int    picks_seen;
  int    items_sent;
  int    send_idle_pct;
  int    recv_stall_pct;
  logic  long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("weighted_best_of_two_selector_top_test: errors");
    $finish;
  end

  function automatic logic [31:0] scaled_load(input logic [3:0] idx);
    return lease_shadow[idx] / ({24'd0, weight_shadow[idx]} + 32'd1);
  endfunction

  // update the shadow tables and predict the pick for a select
  function automatic void predict_item(input cmd_item_t it);
    logic [3:0] cand [NumTargets];
    int n, cnt, p1, p2;
    logic [3:0] a, b;
    pick_t r;
    if (it.command == CMD_WR_COUNT) begin
      lease_shadow[it.target_index] = it.write_value;
    end else if (it.command == CMD_WR_WEIGHT) begin
      weight_shadow[it.target_index] = it.write_value[7:0];
    end else if (it.command == CMD_SELECT) begin
      n = (active_shadow > NumTargets) ? NumTargets : int'(active_shadow);
      cnt = 0;
      for (int i = 0; i < n; i++)
        if (!it.tried_mask[i]) begin
          cand[cnt] = 4'(i);
          cnt++;
        end
      r = '0;
      if (cnt == 0) begin
        r.no_target = 1'b1;
      end else if (cnt == 1) begin
        r.chosen_target = cand[0];
      end else begin
        p1 = int'(it.rand_first % 31'(cnt));
        p2 = int'(it.rand_second % 31'(cnt - 1));
        if (p2 >= p1) p2++;
        a = cand[p1];
        b = cand[p2];
        r.chosen_target = (scaled_load(a) < scaled_load(b)) ? a : b;
      end
      pending_picks.push_back(r);
    end
  endfunction

  // offer one item until taken, idling beforehand at random
  task automatic send_item(input cmd_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.command;
    s_axis_tdata  <= {6'd0, it.rand_second, it.rand_first, it.tried_mask,
                      it.write_value, it.target_index};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(it);
    items_sent++;
  endtask

  task automatic write_active(input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_ACTIVE_TARGETS, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    active_shadow = val[4:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, let every pending pick drain, then cover a full select time
  task automatic drain_picks();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (120) @(posedge clk_i);
  endtask

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int roll;
    it.target_index = 4'($urandom);
    it.write_value  = $urandom;
    it.rand_first   = 31'($urandom);
    it.rand_second  = 31'($urandom);
    it.tried_mask   = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 45) begin
      it.command = CMD_SELECT;
      if ($urandom_range(3) == 0) it.tried_mask = 16'($urandom) & 16'($urandom);
      if ($urandom_range(9) == 0) it.tried_mask = 16'hFFFF;
    end else if (roll < 72) begin
      it.command = CMD_WR_COUNT;
      if ($urandom_range(1) == 0) it.write_value = $urandom_range(300);
    end else if (roll < 97) begin
      it.command = CMD_WR_WEIGHT;
    end else begin
      it.command = 2'd3;
    end
    return it;
  endfunction

  // receiver with random stalls; a raised long_hold holds it off for a counted stretch
  initial begin
    int held;
    held = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold && held < LongHoldCycles) begin
        m_axis_tready <= 1'b0;
        held++;
      end else begin
        if (!long_hold) held = 0;
        m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // result checker
  initial begin
    pick_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        picks_seen++;
        if (pending_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pick: target %0d none %0b", m_axis_tdata[3:0], m_axis_tuser[0]);
        end else begin
          want = pending_picks.pop_front();
          if (m_axis_tdata[3:0] !== want.chosen_target || m_axis_tuser[0] !== want.no_target
              || m_axis_tdata[7:4] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pick mismatch: want target %0d none %0b, got %0d none %0b",
                       want.chosen_target, want.no_target, m_axis_tdata[3:0],
                       m_axis_tuser[0]);
          end
        end
      end
    end
  end

  // directed rows: command, index, value, mask, rand1, rand2, check, target, none
  typedef struct {
    cmd_item_t it;
    bit        typed;
    pick_t     want;
  } row_t;

  task automatic run_rows();
    row_t rows[$];
    row_t r;
    pick_t got;
    // select after reset: all loads zero, tie goes to second
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h0000, 31'd0, 31'd0}; r.typed = 1;
    r.want = '{4'd1, 1'b0}; rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF};
    r.want = '{4'd0, 1'b1}; rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h7FFF, 31'h7FFFFFFF, 31'd0};
    r.want = '{4'd15, 1'b0}; rows.push_back(r);
    r.typed = 0; r.want = '0;
    r.it = '{CMD_WR_COUNT, 4'd15, 32'hFFFFFFFF, 16'd0, 31'd0, 31'd0}; rows.push_back(r);
    r.it = '{CMD_WR_WEIGHT, 4'd15, 32'hFFFFFFFF, 16'd0, 31'd0, 31'd0}; rows.push_back(r);
    r.it = '{CMD_WR_COUNT, 4'd0, 32'd1000, 16'd0, 31'd0, 31'd0}; rows.push_back(r);
    r.it = '{CMD_WR_WEIGHT, 4'd0, 32'hABCD0009, 16'd0, 31'd0, 31'd0}; rows.push_back(r);
    r.it = '{2'd3, 4'd1, 32'hFFFFFFFF, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF};
    rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h7FFE, 31'd0, 31'd0}; rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h7FFE, 31'd1, 31'd0}; rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h5555, 31'h7FFFFFFF, 31'h7FFFFFFF};
    rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'hAAAA, 31'h12345678, 31'h6543210F};
    rows.push_back(r);
    r.it = '{CMD_SELECT, 4'd0, 32'd0, 16'h0000, 31'h55555555, 31'h2AAAAAAA};
    rows.push_back(r);
    foreach (rows[k]) begin
      send_item(rows[k].it);
      if (rows[k].typed) begin
        got = pending_picks[pending_picks.size() - 1];
        if (got !== rows[k].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d model disagrees with table: %0d/%0b vs %0d/%0b", k,
                     got.chosen_target, got.no_target, rows[k].want.chosen_target,
                     rows[k].want.no_target);
        end
      end
    end
  endtask

  initial begin
    int waited;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; picks_seen = 0; items_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1'b0;
    active_shadow = ActiveReset;
    for (int i = 0; i < NumTargets; i++) begin
      lease_shadow[i] = '0;
      weight_shadow[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows();
    drain_picks();

    // a single active target, then none, then more than the table holds
    write_active(32'd1);
    send_item('{CMD_SELECT, 4'd0, 32'd0, 16'h0000, 31'd7, 31'd9});
    send_item('{CMD_SELECT, 4'd0, 32'd0, 16'h0001, 31'd7, 31'd9});
    drain_picks();
    write_active(32'd0);
    send_item('{CMD_SELECT, 4'd0, 32'd0, 16'h0000, 31'd3, 31'd4});
    drain_picks();
    write_active(32'd31);
    send_item('{CMD_SELECT, 4'd0, 32'd0, 16'h0000, 31'd3, 31'd4});
    drain_picks();

    // long receiver hold-off while items keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_item('{CMD_SELECT, 4'd0, 32'd0, 16'($urandom), 31'($urandom), 31'($urandom)});
    drain_picks();
    long_hold = 1'b0;

    // random phases with differing idle mixes and active counts
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_active(ph == 0 ? 32'd16 : ph == 7 ? 32'd2 : 32'($urandom_range(20)));
      for (int i = 0; i < 165; i++) send_item(random_item());
      drain_picks();
    end

    waited = 0;
    while (pending_picks.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);
    $display("sent %0d items, checked %0d picks over several active counts and idle mixes",
             items_sent, picks_seen);
    if (mismatches == 0 && pending_picks.size() == 0)
      $display("weighted_best_of_two_selector_top_test: clean");
    else
      $display("weighted_best_of_two_selector_top_test: errors");
    $finish;
  end
endmodule
`default_nettype wire
